### src/axis_angle_rotation_matrix_top_macros.svh
// assertion macros for the rotation matrix rtl
// depends on nothing; included by the top level, which checks its own logic
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define AARM_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define AARM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/aarm_pkg.sv
// shared types, constants and rounding helper for the rotation matrix pipeline
// no dependencies; imported by aarm_norm, aarm_sincos and the top level
package aarm_pkg;

    // field and datapath widths
    localparam int unsigned FIELD_W = 24;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned MAG_W   = 24;
    localparam int unsigned SQ_W    = 47;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned ROOT_W  = 24;
    localparam int unsigned REM_W   = ROOT_W + 2;
    localparam int unsigned NUM_W   = MAG_W + 22;
    localparam int unsigned QUOT_W  = 23;
    localparam int unsigned ANG_W   = 35;
    localparam int unsigned AMAG_W  = 31;
    localparam int unsigned T_W     = 31;
    localparam int unsigned TRIG_W  = 32;

    // angle constants in Q30
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] THREE_PI_Q30 = 35'sd10119778278;
    localparam logic signed [ANG_W-1:0] FOUR_PI_Q30 = 35'sd13493037704;
    localparam logic [T_W-1:0]          Q30_ONE     = 31'd1073741824;
    localparam logic [63:0]             Q30_HALF    = 64'd536870912;
    localparam logic signed [FIELD_W-1:0] ONE_Q22   = 24'sd4194304;

    // horner step divisors; a zero divisor marks a pass-through step
    localparam int unsigned N_SLOT = 6;
    localparam int unsigned SIN_DIV [N_SLOT] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [N_SLOT] = '{0, 132, 90, 56, 30, 12};
    localparam int unsigned RCP_SH = 34;

    // reset value of the angle threshold
    localparam logic [CFG_W-1:0] THRESH_RESET = 20'd1;

    // stage counts
    localparam int unsigned T_ROOT  = 27;
    localparam int unsigned T_QUOT  = 50;
    localparam int unsigned T_TRIG  = 57;
    localparam int unsigned LAT     = 63;

    // signs of the three vector components
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } aarm_sign_t;

    // arithmetic right shift rounded half away from zero
    function automatic logic signed [63:0] rnd_away(input logic signed [63:0] val,
                                                    input int unsigned sh);
        logic [63:0] mag_v;
        logic [63:0] half_v;
        mag_v  = val[63] ? 64'(-val) : 64'(val);
        half_v = 64'd1 << (sh - 1);
        mag_v  = (mag_v + half_v) >> sh;
        return val[63] ? -$signed(mag_v) : $signed(mag_v);
    endfunction

endpackage

### src/aarm_norm.sv
// vector length by a pipelined digit square root, then axis components by
// three pipelined restoring dividers; depends on aarm_pkg
module aarm_norm (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [aarm_pkg::SUM_W-1:0]    sum_sq,
    input  logic [aarm_pkg::MAG_W-1:0]    mag_x,
    input  logic [aarm_pkg::MAG_W-1:0]    mag_y,
    input  logic [aarm_pkg::MAG_W-1:0]    mag_z,
    input  aarm_pkg::aarm_sign_t          sign_in,
    output logic [aarm_pkg::ROOT_W-1:0]   root,
    output logic [aarm_pkg::QUOT_W-1:0]   quot_x,
    output logic [aarm_pkg::QUOT_W-1:0]   quot_y,
    output logic [aarm_pkg::QUOT_W-1:0]   quot_z,
    output aarm_pkg::aarm_sign_t          sign_out
);
    import aarm_pkg::*;

    // square root stages
    logic [SUM_W-1:0]  val_reg   [ROOT_W];
    logic [REM_W-1:0]  srem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sroot_reg [ROOT_W];
    logic [MAG_W-1:0]  smag_reg  [ROOT_W][3];
    aarm_sign_t        ssign_reg [ROOT_W];

    // divider stages
    logic [NUM_W-1:0]  drem_reg  [QUOT_W][3];
    logic [QUOT_W-1:0] dq_reg    [QUOT_W][3];
    logic [ROOT_W-1:0] dv_reg    [QUOT_W];
    aarm_sign_t        dsign_reg [QUOT_W];

    genvar i, j, l;

    // one root bit per stage, two radicand bits consumed each time
    generate
        for (i = 0; i < ROOT_W; i++) begin : g_sqrt
            localparam int K = ROOT_W - 1 - i;
            logic [SUM_W-1:0]  val_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [MAG_W-1:0]  mag_in [3];
            aarm_sign_t        sign_s;
            logic [REM_W+1:0]  rem_sh;
            logic [REM_W+1:0]  trial;
            logic              ge;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (i == 0) begin : g_first
                assign val_in    = sum_sq;
                assign rem_in    = '0;
                assign root_in   = '0;
                assign mag_in[0] = mag_x;
                assign mag_in[1] = mag_y;
                assign mag_in[2] = mag_z;
                assign sign_s    = sign_in;
            end else begin : g_rest
                assign val_in    = val_reg[i-1];
                assign rem_in    = srem_reg[i-1];
                assign root_in   = sroot_reg[i-1];
                assign mag_in[0] = smag_reg[i-1][0];
                assign mag_in[1] = smag_reg[i-1][1];
                assign mag_in[2] = smag_reg[i-1][2];
                assign sign_s    = ssign_reg[i-1];
            end

            always_comb begin
                rem_sh    = {rem_in, val_in[2*K +: 2]};
                trial     = {root_in, 2'b01};
                ge        = (rem_sh >= trial);
                rem_next  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_next = {root_in[ROOT_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    val_reg[i]     <= val_in;
                    srem_reg[i]    <= rem_next;
                    sroot_reg[i]   <= root_next;
                    smag_reg[i][0] <= mag_in[0];
                    smag_reg[i][1] <= mag_in[1];
                    smag_reg[i][2] <= mag_in[2];
                    ssign_reg[i]   <= sign_s;
                end
            end
        end
    endgenerate

    // divisor and signs travel beside the quotient bits
    generate
        for (j = 0; j < QUOT_W; j++) begin : g_dctl
            logic [ROOT_W-1:0] dv_next;
            aarm_sign_t        dsign_next;
            if (j == 0) begin : g_first
                assign dv_next    = sroot_reg[ROOT_W-1];
                assign dsign_next = ssign_reg[ROOT_W-1];
            end else begin : g_rest
                assign dv_next    = dv_reg[j-1];
                assign dsign_next = dsign_reg[j-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_reg[j]    <= dv_next;
                    dsign_reg[j] <= dsign_next;
                end
            end
        end
    endgenerate

    // one quotient bit per stage and lane, msb first
    generate
        for (j = 0; j < QUOT_W; j++) begin : g_div
            localparam int B = QUOT_W - 1 - j;
            for (l = 0; l < 3; l++) begin : g_lane
                logic [NUM_W-1:0]  rem_in;
                logic [QUOT_W-1:0] q_in;
                logic [ROOT_W-1:0] dv_in;
                logic [NUM_W:0]    sub;
                logic              ge;
                logic [NUM_W-1:0]  rem_next;
                logic [QUOT_W-1:0] q_next;

                if (j == 0) begin : g_first
                    assign rem_in = {smag_reg[ROOT_W-1][l], 22'd0};
                    assign q_in   = '0;
                    assign dv_in  = sroot_reg[ROOT_W-1];
                end else begin : g_rest
                    assign rem_in = drem_reg[j-1][l];
                    assign q_in   = dq_reg[j-1][l];
                    assign dv_in  = dv_reg[j-1];
                end

                always_comb begin
                    sub      = (NUM_W+1)'(dv_in) << B;
                    ge       = ((NUM_W+1)'(rem_in) >= sub);
                    rem_next = ge ? NUM_W'((NUM_W+1)'(rem_in) - sub) : rem_in;
                    q_next   = q_in;
                    q_next[B] = ge;
                end

                always_ff @(posedge aclk) begin
                    if (en) begin
                        drem_reg[j][l] <= rem_next;
                        dq_reg[j][l]   <= q_next;
                    end
                end
            end
        end
    endgenerate

    assign root     = sroot_reg[ROOT_W-1];
    assign quot_x   = dq_reg[QUOT_W-1][0];
    assign quot_y   = dq_reg[QUOT_W-1][1];
    assign quot_z   = dq_reg[QUOT_W-1][2];
    assign sign_out = dsign_reg[QUOT_W-1];

endmodule

### src/aarm_sincos.sv
// angle reduction and horner sine and cosine in Q30, thirty register stages
// depends on aarm_pkg
module aarm_sincos (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [aarm_pkg::ROOT_W-1:0]         root,
    output logic signed [aarm_pkg::TRIG_W-1:0]  sin_q30,
    output logic signed [aarm_pkg::TRIG_W-1:0]  cos_q30
);
    import aarm_pkg::*;

    localparam int unsigned N_STG = 4 * N_SLOT;
    localparam int unsigned P_W   = 63;

    // front stages
    logic signed [ANG_W-1:0] ared_reg, ared_next;
    logic [AMAG_W-1:0]       amag_reg, amag_next;
    logic                    sneg_reg, sneg_next;
    logic                    cneg_reg, cneg_next;
    logic [61:0]             sq_reg, sq_next;
    logic [AMAG_W-1:0]       amag3_reg;
    logic                    sneg3_reg, cneg3_reg;
    logic [31:0]             a2_reg, a2_next;
    logic [AMAG_W-1:0]       amag4_reg;
    logic                    sneg4_reg, cneg4_reg;

    // side data carried through the horner stages
    logic [AMAG_W-1:0]       car_amag [N_STG];
    logic [31:0]             car_a2   [N_STG];
    logic [N_STG-1:0]        car_sneg;
    logic [N_STG-1:0]        car_cneg;

    logic [T_W-1:0]          t_out [2][N_SLOT];

    // final stages
    logic [P_W-1:0]          ps_reg, ps_next;
    logic [P_W-1:0]          pc_reg, pc_next;
    logic                    snegf_reg, cnegf_reg;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;

    // range reduction: subtract two pi while above pi, at most twice
    // the longest vector stays below five pi, so two subtractions suffice
    always_comb begin
        logic signed [ANG_W-1:0] a0;
        logic signed [ANG_W-1:0] sub;
        a0 = $signed({1'b0, root, 10'd0});
        if (a0 > THREE_PI_Q30) begin
            sub = FOUR_PI_Q30;
        end else if (a0 > PI_Q30) begin
            sub = TWO_PI_Q30;
        end else begin
            sub = '0;
        end
        ared_next = a0 - sub;
    end

    // fold into plus or minus half pi
    always_comb begin
        logic signed [ANG_W-1:0] af;
        cneg_next = 1'b0;
        if (ared_reg > HALF_PI_Q30) begin
            af        = PI_Q30 - ared_reg;
            cneg_next = 1'b1;
        end else if (ared_reg < -HALF_PI_Q30) begin
            af        = -PI_Q30 - ared_reg;
            cneg_next = 1'b1;
        end else begin
            af = ared_reg;
        end
        sneg_next = af[ANG_W-1];
        amag_next = af[ANG_W-1] ? AMAG_W'(-af) : AMAG_W'(af);
    end

    // angle squared, then rounded to Q30
    always_comb begin
        sq_next = 62'(amag_reg) * 62'(amag_reg);
        a2_next = 32'((64'(sq_reg) + Q30_HALF) >> 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ared_reg  <= ared_next;
            amag_reg  <= amag_next;
            sneg_reg  <= sneg_next;
            cneg_reg  <= cneg_next;
            sq_reg    <= sq_next;
            amag3_reg <= amag_reg;
            sneg3_reg <= sneg_reg;
            cneg3_reg <= cneg_reg;
            a2_reg    <= a2_next;
            amag4_reg <= amag3_reg;
            sneg4_reg <= sneg3_reg;
            cneg4_reg <= cneg3_reg;
        end
    end

    genvar g, f, j;

    // carry line
    generate
        for (g = 0; g < N_STG; g++) begin : g_car
            if (g == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        car_amag[g] <= amag4_reg;
                        car_a2[g]   <= a2_reg;
                        car_sneg[g] <= sneg4_reg;
                        car_cneg[g] <= cneg4_reg;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge aclk) begin
                    if (en) begin
                        car_amag[g] <= car_amag[g-1];
                        car_a2[g]   <= car_a2[g-1];
                        car_sneg[g] <= car_sneg[g-1];
                        car_cneg[g] <= car_cneg[g-1];
                    end
                end
            end
        end
    endgenerate

    // horner steps: multiply, round, reciprocal multiply, correct
    generate
        for (f = 0; f < 2; f++) begin : g_fn
            for (j = 0; j < N_SLOT; j++) begin : g_slot
                localparam int unsigned DIV = (f == 0) ? SIN_DIV[j] : COS_DIV[j];
                if (DIV != 0) begin : g_step
                    localparam logic [31:0] RECIP = 32'((64'd1 << RCP_SH) / DIV);
                    logic [T_W-1:0] t_in;
                    logic [31:0]    a2_in;
                    logic [P_W-1:0] prod_reg, prod_next;
                    logic [31:0]    x_reg, x_next;
                    logic [63:0]    qm_reg, qm_next;
                    logic [31:0]    xq_reg;
                    logic [T_W-1:0] t_reg, t_next;

                    if (j == 0) begin : g_t0
                        assign t_in  = Q30_ONE;
                        assign a2_in = a2_reg;
                    end else begin : g_tn
                        assign t_in  = t_out[f][j-1];
                        assign a2_in = car_a2[4*j-1];
                    end

                    always_comb begin
                        logic [29:0] q0;
                        logic [31:0] rem;
                        logic [29:0] q;
                        prod_next = P_W'(a2_in) * P_W'(t_in);
                        x_next    = 32'((64'(prod_reg) + Q30_HALF) >> 30);
                        qm_next   = 64'(x_reg) * 64'(RECIP);
                        q0        = qm_reg[63:RCP_SH];
                        rem       = xq_reg - 32'(32'(q0) * 32'(DIV));
                        q         = (rem >= 32'(DIV)) ? q0 + 30'd1 : q0;
                        t_next    = Q30_ONE - T_W'(q);
                    end

                    always_ff @(posedge aclk) begin
                        if (en) begin
                            prod_reg <= prod_next;
                            x_reg    <= x_next;
                            qm_reg   <= qm_next;
                            xq_reg   <= x_reg;
                            t_reg    <= t_next;
                        end
                    end

                    assign t_out[f][j] = t_reg;
                end else begin : g_pass
                    assign t_out[f][j] = Q30_ONE;
                end
            end
        end
    endgenerate

    // last products, rounding and signs
    always_comb begin
        logic [31:0] hc;
        logic [30:0] sm;
        ps_next  = P_W'(car_amag[N_STG-1]) * P_W'(t_out[0][N_SLOT-1]);
        pc_next  = P_W'(car_a2[N_STG-1]) * P_W'(t_out[1][N_SLOT-1]);
        sm       = 31'((64'(ps_reg) + Q30_HALF) >> 30);
        hc       = 32'((64'(pc_reg) + Q30_HALF) >> 30);
        sin_next = snegf_reg ? -$signed(32'(sm)) : $signed(32'(sm));
        cos_next = $signed(32'(Q30_ONE)) - $signed(32'(hc >> 1));
        if (cnegf_reg) begin
            cos_next = -cos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ps_reg    <= ps_next;
            pc_reg    <= pc_next;
            snegf_reg <= car_sneg[N_STG-1];
            cnegf_reg <= car_cneg[N_STG-1];
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

### src/axis_angle_rotation_matrix_top.sv
// rotation vector to 3x3 rotation matrix, axis-angle form, streaming in and out
// the pipeline is 63 register stages deep
// throughput 1 item per cycle; the whole pipeline holds while the output item waits
// reset (aresetn low, synchronous) empties the pipeline and sets the threshold to 1
// depends on aarm_pkg, aarm_norm, aarm_sincos and the assertion macro header
`include "axis_angle_rotation_matrix_top_macros.svh"

module axis_angle_rotation_matrix_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // angle threshold write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aarm_pkg::CFG_W-1:0]       cfg_data,
    // input item
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [71:0]                      s_tdata,  // axis_x, axis_y, axis_z
    // result item
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2, m_r2_c0, m_r2_c1, m_r2_c2
    output logic [215:0]                     m_tdata,
    output logic                             m_tuser   // is_identity
);
    import aarm_pkg::*;

    localparam int unsigned ID_LEN = LAT - 1 - T_ROOT;
    localparam int unsigned ND_LEN = T_TRIG - T_QUOT;

    logic              pipe_en;
    logic [LAT-1:0]    vld_reg;
    logic [CFG_W-1:0]  thr_reg;

    // input and square stages
    logic [MAG_W-1:0]  mag1_reg [3];
    aarm_sign_t        sign1_reg;
    logic [SQ_W-1:0]   sq2_reg  [3];
    logic [MAG_W-1:0]  mag2_reg [3];
    aarm_sign_t        sign2_reg;
    logic [SUM_W-1:0]  sum3_reg;
    logic [MAG_W-1:0]  mag3_reg [3];
    aarm_sign_t        sign3_reg;

    logic [ROOT_W-1:0] root;
    logic [QUOT_W-1:0] quot [3];
    aarm_sign_t        qsign;
    logic signed [TRIG_W-1:0] sin_q30, cos_q30;

    logic              ident_next;
    logic [ID_LEN-1:0] id_reg;
    logic signed [FIELD_W-1:0] nd_reg [ND_LEN][3];

    // matrix stages
    logic signed [45:0]  nn1_reg  [6];
    logic signed [55:0]  ns1_reg  [3];
    logic signed [31:0]  c1_reg;
    logic signed [32:0]  t1_reg;
    logic signed [31:0]  p2_reg   [6];
    logic signed [31:0]  sn2_reg  [3];
    logic signed [31:0]  c2_reg;
    logic signed [32:0]  t2_reg;
    logic signed [63:0]  m3_reg   [6];
    logic signed [31:0]  sn3_reg  [3];
    logic signed [31:0]  c3_reg;
    logic signed [32:0]  v4_reg   [6];
    logic signed [31:0]  sn4_reg  [3];
    logic signed [31:0]  c4_reg;
    logic signed [33:0]  sum5_reg [9];
    logic signed [33:0]  sum5_next [9];
    logic signed [FIELD_W-1:0] out_reg [9];
    logic signed [FIELD_W-1:0] out_next [9];
    logic              ident_out_reg;

    // whole pipeline moves unless the output item is held
    assign pipe_en  = ~vld_reg[LAT-1] | m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    // valid line and threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            thr_reg <= THRESH_RESET;
        end else begin
            if (pipe_en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
        end
    end

    // split components into magnitude and sign, square, sum
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [FIELD_W-1:0] v;
                v = s_tdata[FIELD_W*k +: FIELD_W];
                mag1_reg[k] <= v[FIELD_W-1] ? MAG_W'(-v) : MAG_W'(v);
                sq2_reg[k]  <= SQ_W'(48'(mag1_reg[k]) * 48'(mag1_reg[k]));
                mag2_reg[k] <= mag1_reg[k];
                mag3_reg[k] <= mag2_reg[k];
            end
            sign1_reg.neg_x <= s_tdata[FIELD_W-1];
            sign1_reg.neg_y <= s_tdata[2*FIELD_W-1];
            sign1_reg.neg_z <= s_tdata[3*FIELD_W-1];
            sign2_reg <= sign1_reg;
            sign3_reg <= sign2_reg;
            sum3_reg  <= SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
        end
    end

    aarm_norm u_norm (
        .aclk     (aclk),
        .en       (pipe_en),
        .sum_sq   (sum3_reg),
        .mag_x    (mag3_reg[0]),
        .mag_y    (mag3_reg[1]),
        .mag_z    (mag3_reg[2]),
        .sign_in  (sign3_reg),
        .root     (root),
        .quot_x   (quot[0]),
        .quot_y   (quot[1]),
        .quot_z   (quot[2]),
        .sign_out (qsign)
    );

    aarm_sincos u_sincos (
        .aclk    (aclk),
        .en      (pipe_en),
        .root    (root),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    // zero length or below threshold gives the identity
    assign ident_next = (root == '0) || (root < ROOT_W'(thr_reg));

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            id_reg <= {id_reg[ID_LEN-2:0], ident_next};
        end
    end

    // sign the axis components and align them with sine and cosine
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nd_reg[0][0] <= qsign.neg_x ? -$signed(24'(quot[0])) : $signed(24'(quot[0]));
            nd_reg[0][1] <= qsign.neg_y ? -$signed(24'(quot[1])) : $signed(24'(quot[1]));
            nd_reg[0][2] <= qsign.neg_z ? -$signed(24'(quot[2])) : $signed(24'(quot[2]));
            for (int k = 1; k < ND_LEN; k++) begin
                nd_reg[k] <= nd_reg[k-1];
            end
        end
    end

    // axis products and sine terms
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nn1_reg[0] <= 46'(nd_reg[ND_LEN-1][0] * nd_reg[ND_LEN-1][0]);
            nn1_reg[1] <= 46'(nd_reg[ND_LEN-1][1] * nd_reg[ND_LEN-1][1]);
            nn1_reg[2] <= 46'(nd_reg[ND_LEN-1][2] * nd_reg[ND_LEN-1][2]);
            nn1_reg[3] <= 46'(nd_reg[ND_LEN-1][0] * nd_reg[ND_LEN-1][1]);
            nn1_reg[4] <= 46'(nd_reg[ND_LEN-1][0] * nd_reg[ND_LEN-1][2]);
            nn1_reg[5] <= 46'(nd_reg[ND_LEN-1][1] * nd_reg[ND_LEN-1][2]);
            for (int k = 0; k < 3; k++) begin
                ns1_reg[k] <= 56'(nd_reg[ND_LEN-1][k] * sin_q30);
            end
            c1_reg <= cos_q30;
            t1_reg <= $signed(33'(Q30_ONE)) - 33'(cos_q30);
        end
    end

    // round to Q30, multiply by one minus cosine, round again
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 6; k++) begin
                p2_reg[k] <= 32'(rnd_away(64'(nn1_reg[k]), 14));
                m3_reg[k] <= 64'(p2_reg[k] * t2_reg);
                v4_reg[k] <= 33'(rnd_away(m3_reg[k], 30));
            end
            for (int k = 0; k < 3; k++) begin
                sn2_reg[k] <= 32'(rnd_away(64'(ns1_reg[k]), 22));
                sn3_reg[k] <= sn2_reg[k];
                sn4_reg[k] <= sn3_reg[k];
            end
            c2_reg <= c1_reg;
            t2_reg <= t1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
        end
    end

    // entry sums in row-major order
    always_comb begin
        sum5_next[0] = 34'(c4_reg) + 34'(v4_reg[0]);
        sum5_next[1] = 34'(v4_reg[3]) + 34'(sn4_reg[2]);
        sum5_next[2] = 34'(v4_reg[4]) - 34'(sn4_reg[1]);
        sum5_next[3] = 34'(v4_reg[3]) - 34'(sn4_reg[2]);
        sum5_next[4] = 34'(c4_reg) + 34'(v4_reg[1]);
        sum5_next[5] = 34'(v4_reg[5]) + 34'(sn4_reg[0]);
        sum5_next[6] = 34'(v4_reg[4]) + 34'(sn4_reg[1]);
        sum5_next[7] = 34'(v4_reg[5]) - 34'(sn4_reg[0]);
        sum5_next[8] = 34'(c4_reg) + 34'(v4_reg[2]);
    end

    // round to Q22, saturate, or substitute the identity
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            logic signed [63:0] r;
            r = rnd_away(64'(sum5_reg[k]), 8);
            if (id_reg[ID_LEN-1]) begin
                out_next[k] = (k % 4 == 0) ? ONE_Q22 : '0;
            end else if (r > 64'(ONE_Q22)) begin
                out_next[k] = ONE_Q22;
            end else if (r < -64'(ONE_Q22)) begin
                out_next[k] = -ONE_Q22;
            end else begin
                out_next[k] = FIELD_W'(r);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sum5_reg      <= sum5_next;
            out_reg       <= out_next;
            ident_out_reg <= id_reg[ID_LEN-1];
        end
    end

    // pack entries, first one in the lowest bits
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m_tdata[FIELD_W*k +: FIELD_W] = out_reg[k];
        end
    end
    assign m_tuser = ident_out_reg;

    // identity results carry the exact identity pattern
    `AARM_ASSERT_NOW(a_ident_pattern, aclk, aresetn, m_tvalid && m_tuser, (m_tdata[23:0] == 24'h400000) && (m_tdata[47:24] == 24'h0) && (m_tdata[215:192] == 24'h400000), "identity item with wrong entries")
    // a stalled pipeline keeps all its items
    `AARM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !pipe_en, $stable(vld_reg), "valid line moved during stall")
    // a zero length always selects the identity
    `AARM_ASSERT_NEXT(a_zero_len, aclk, aresetn, pipe_en && vld_reg[T_ROOT-1] && (root == '0), id_reg[0], "zero length did not select identity")

endmodule

### tb/axis_angle_rotation_matrix_top_tb.sv
// self-checking testbench for the axis-angle rotation matrix block
// holds its own fixed-point predictor of the matrix; depends on aarm_pkg and the top level
module axis_angle_rotation_matrix_top_tb;
    import aarm_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int WATCH_LIMIT = 3000;
    localparam int DRAIN_CYCLES = LAT + 10;

    typedef struct {
        logic [215:0] matrix;
        logic         ident;
    } rot_result_t;

    // expected matrices in input order, with a fixed-point rotation predictor
    class rotation_scoreboard;
        rot_result_t     pending_q[$];
        logic [CFG_W-1:0] threshold = THRESH_RESET;
        int              errors = 0;
        int              seen = 0;

        function automatic logic [63:0] umag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // product shifted right, rounded half away from zero
        function automatic longint mul_round(longint a, longint b, int sh);
            logic [63:0] p;
            p = umag(a) * umag(b);
            if (sh > 0) p = (p + (64'd1 << (sh - 1))) >> sh;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        function automatic logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // horner sine and cosine of an angle in [0, pi/2], q30
        function automatic longint sine_q30(logic [63:0] a);
            logic [63:0] a2, t;
            a2 = (a * a + Q30_HALF) >> 30;
            t = 64'(Q30_ONE);
            for (int i = 0; i < N_SLOT; i++)
                t = 64'(Q30_ONE) - ((a2 * t + Q30_HALF) >> 30) / 64'(SIN_DIV[i]);
            return longint'((a * t + Q30_HALF) >> 30);
        endfunction

        function automatic longint cosine_q30(logic [63:0] a);
            logic [63:0] a2, t;
            a2 = (a * a + Q30_HALF) >> 30;
            t = 64'(Q30_ONE);
            for (int i = 1; i < N_SLOT; i++)
                t = 64'(Q30_ONE) - ((a2 * t + Q30_HALF) >> 30) / 64'(COS_DIV[i]);
            return longint'(Q30_ONE) - longint'(((a2 * t + Q30_HALF) >> 30) / 64'd2);
        endfunction

        function automatic logic [23:0] to_q22(longint q30);
            longint v;
            v = mul_round(q30, 1, 8);
            if (v > 4194304) v = 4194304;
            if (v < -4194304) v = -4194304;
            return v[23:0];
        endfunction

        function automatic longint unit_comp(longint v, logic [63:0] r);
            logic [63:0] q;
            q = (umag(v) << 22) / r;
            return v < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_input(logic [71:0] vec);
            longint x, y, z, nx, ny, nz, a, s, c, t;
            longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
            logic [63:0] r;
            logic cneg;
            rot_result_t e;
            x = longint'($signed(vec[23:0]));
            y = longint'($signed(vec[47:24]));
            z = longint'($signed(vec[71:48]));
            r = int_sqrt(umag(x) * umag(x) + umag(y) * umag(y) + umag(z) * umag(z));
            if (r == 0 || r < 64'(threshold)) begin
                e.matrix = '0;
                e.matrix[23:0] = 24'd4194304;
                e.matrix[4*24 +: 24] = 24'd4194304;
                e.matrix[8*24 +: 24] = 24'd4194304;
                e.ident = 1'b1;
                pending_q.push_back(e);
                return;
            end
            nx = unit_comp(x, r);
            ny = unit_comp(y, r);
            nz = unit_comp(z, r);
            // fold the angle into [-pi/2, pi/2]
            a = longint'(r << 10);
            cneg = 1'b0;
            for (int i = 0; i < 3; i++)
                if (a > longint'(PI_Q30)) a -= longint'(TWO_PI_Q30);
            if (a > longint'(HALF_PI_Q30)) begin
                a = longint'(PI_Q30) - a;
                cneg = 1'b1;
            end else if (a < -longint'(HALF_PI_Q30)) begin
                a = -longint'(PI_Q30) - a;
                cneg = 1'b1;
            end
            s = sine_q30(umag(a));
            if (a < 0) s = -s;
            c = cosine_q30(umag(a));
            if (cneg) c = -c;
            t = longint'(Q30_ONE) - c;
            xx = mul_round(mul_round(nx, nx, 14), t, 30);
            yy = mul_round(mul_round(ny, ny, 14), t, 30);
            zz = mul_round(mul_round(nz, nz, 14), t, 30);
            xy = mul_round(mul_round(nx, ny, 14), t, 30);
            xz = mul_round(mul_round(nx, nz, 14), t, 30);
            yz = mul_round(mul_round(ny, nz, 14), t, 30);
            sx = mul_round(nx, s, 22);
            sy = mul_round(ny, s, 22);
            sz = mul_round(nz, s, 22);
            e.matrix = {to_q22(c + zz), to_q22(yz - sx), to_q22(xz + sy),
                        to_q22(yz + sx), to_q22(c + yy), to_q22(xy - sz),
                        to_q22(xz - sy), to_q22(xy + sz), to_q22(c + xx)};
            e.ident = 1'b0;
            pending_q.push_back(e);
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            errors++;
            $display("mismatch item %0d %s: got %0d want %0d", seen, what,
                     $signed(got), $signed(want));
        endtask

        task check_result(logic [215:0] matrix, logic ident);
            rot_result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                $display("unexpected matrix item %0d", seen);
                seen++;
                return;
            end
            e = pending_q.pop_front();
            for (int i = 0; i < 9; i++)
                if (matrix[i*24 +: 24] !== e.matrix[i*24 +: 24])
                    report($sformatf("r%0d_c%0d", i / 3, i % 3),
                           matrix[i*24 +: 24], e.matrix[i*24 +: 24]);
            if (ident !== e.ident)
                report("is_identity", 24'(ident), 24'(e.ident));
            seen++;
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [215:0] m_tdata;
    logic m_tuser;

    rotation_scoreboard rot_sb;
    bit hold_request = 0;
    int idle_cycles = 0;

    always #6 aclk = ~aclk;

    axis_angle_rotation_matrix_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // observe handshakes mid-cycle, where all driven values are settled
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) rot_sb.note_input(s_tdata);
            if (m_tvalid && m_tready) rot_sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        bit fired;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do begin
                @(negedge aclk);
                fired = m_tvalid;
                @(posedge aclk);
            end while (!fired);
        end
    end

    task automatic write_threshold(logic [CFG_W-1:0] value);
        bit fired;
        cfg_valid <= 1;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            fired = cfg_ready;
            @(posedge aclk);
        end while (!fired);
        cfg_valid <= 0;
        rot_sb.threshold = value;
    endtask

    task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z, int gap);
        bit fired;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do begin
            @(negedge aclk);
            fired = s_tready;
            @(posedge aclk);
        end while (!fired);
    endtask

    function automatic logic [23:0] rand_comp(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 2**21)) - 2**20);
            2: return 24'($signed($urandom_range(0, 2**23)) - 2**22);
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic send_random(int count, bit bursty);
        int mode, gap;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
            gap = bursty ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
            send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode), gap);
        end
    endtask

    // stop sending, wait for all expected matrices, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 0;
        while (rot_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        rot_sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed vectors at the reset threshold
        send_vector(24'd0, 24'd0, 24'd0, 0);
        send_vector(24'd1, 24'd0, 24'd0, 0);
        send_vector(24'h7FFFFF, 24'd0, 24'd0, 2);
        send_vector(24'h800000, 24'd0, 24'd0, 0);
        send_vector(24'd0, 24'h7FFFFF, 24'd0, 0);
        send_vector(24'd0, 24'h800000, 24'd0, 1);
        send_vector(24'd0, 24'd0, 24'h7FFFFF, 0);
        send_vector(24'd0, 24'd0, 24'h800000, 0);
        send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
        send_vector(24'h800000, 24'h800000, 24'h800000, 3);
        send_vector(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0);
        send_vector(24'd3373260, 24'd0, 24'd0, 0);      // a little above pi
        send_vector(24'd1647099, 24'd0, 24'd0, 0);      // about pi/2
        send_vector(24'd0, 24'hE6DE04, 24'd0, 0);       // about -pi/2
        send_vector(24'd6588397, 24'd0, 24'd0, 0);      // about 2 pi
        send_vector(24'd600000, 24'hF6C000, 24'd300000, 0);
        send_vector(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        wait_idle();

        // zero threshold: only a zero vector gives the identity
        write_threshold('0);
        send_vector(24'd0, 24'd0, 24'd0, 0);
        send_vector(24'd1, 24'd0, 24'd0, 0);
        send_vector(24'hFFFFFF, 24'd0, 24'd0, 0);
        send_random(150, 0);
        // back-to-back with the result side held off, so the pipeline fills
        hold_request = 1;
        send_random(60, 1);
        wait_idle();

        // largest threshold, at it and just above
        write_threshold(20'hFFFFF);
        send_vector(24'hFFFFF, 24'd0, 24'd0, 0);
        send_vector(24'h100000, 24'd0, 24'd0, 0);
        send_vector(24'd0, 24'd0, 24'hF00001, 0);
        send_random(150, 0);
        wait_idle();

        write_threshold(20'($urandom));
        send_random(140, 0);
        wait_idle();

        write_threshold(THRESH_RESET);
        send_random(140, 0);
        wait_idle();

        if (rot_sb.errors == 0 && rot_sb.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### axis_angle_rotation_matrix_top.f
+incdir+src
src/aarm_pkg.sv
src/aarm_norm.sv
src/aarm_sincos.sv
src/axis_angle_rotation_matrix_top.sv
tb/axis_angle_rotation_matrix_top_tb.sv
